>>> rtl/core/led_strip_rainbow_frame_engine_unit_macros.svh
// Assertion macros shared by the checker of the LED strip frame engine.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef LED_STRIP_RAINBOW_FRAME_ENGINE_UNIT_MACROS_SVH
`define LED_STRIP_RAINBOW_FRAME_ENGINE_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LSRFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property that must also hold while reset is applied.
`define LSRFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/core/lsrfe_pkg.sv
// Shared types, constants and the color wheel function of the LED strip frame engine.
// Depends on nothing; used by every module of the block.
package lsrfe_pkg;

  localparam int unsigned MAX_LEDS_DEF = 64;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned COL_W  = 8;
  localparam int unsigned GRB_W  = 24;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned BRT_W  = 7;
  localparam int unsigned SPD_W  = 5;
  localparam int unsigned HUE_W  = 8;
  localparam int unsigned PROD_W = COL_W + BRT_W;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SET  = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL = 3'd1;
  localparam logic [OP_W-1:0] OP_HUE  = 3'd2;
  localparam logic [OP_W-1:0] OP_GRAD = 3'd3;
  localparam logic [OP_W-1:0] OP_SHOW = 3'd4;

  // Register indexes (word address bits 3:2)
  localparam logic [1:0] CFG_IDX_COUNT  = 2'd0;
  localparam logic [1:0] CFG_IDX_BRIGHT = 2'd1;
  localparam logic [1:0] CFG_IDX_SPEED  = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_RST  = 7'd1;
  localparam logic [BRT_W-1:0] BRIGHT_RST = 7'd100;
  localparam logic [SPD_W-1:0] SPEED_RST  = 5'd1;
  localparam logic [BRT_W-1:0] BRIGHT_MAX = 7'd100;
  localparam logic [SPD_W-1:0] SPEED_MAX  = 5'd20;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
  localparam int unsigned SCALE_RECIP_W = 13;
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 13'd5243;
  localparam int unsigned SCALE_SHIFT = 19;

  localparam logic [COL_W-1:0] WHEEL_SEG1 = 8'd85;
  localparam logic [COL_W-1:0] WHEEL_SEG2 = 8'd170;
  localparam logic [COL_W-1:0] COL_FULL   = 8'd255;

  // Unscaled wheel color of a hue position, packed green, red, blue
  function automatic logic [GRB_W-1:0] wheel_grb(input logic [HUE_W-1:0] pos);
    logic [COL_W-1:0] q;
    logic [COL_W-1:0] t;
    logic [COL_W-1:0] t3;
    logic [COL_W-1:0] r;
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] b;
    q = COL_FULL - pos;
    if (q < WHEEL_SEG1) begin
      t = q;
    end else if (q < WHEEL_SEG2) begin
      t = q - WHEEL_SEG1;
    end else begin
      t = q - WHEEL_SEG2;
    end
    t3 = COL_W'({2'b00, t} * 10'd3);
    if (q < WHEEL_SEG1) begin
      r = COL_FULL - t3;
      g = '0;
      b = t3;
    end else if (q < WHEEL_SEG2) begin
      r = '0;
      g = t3;
      b = COL_FULL - t3;
    end else begin
      r = t3;
      g = COL_FULL - t3;
      b = '0;
    end
    return {g, r, b};
  endfunction

endpackage

>>> rtl/core/lsrfe_scale.sv
// Brightness scaler: one channel at a time, multiply then divide by 100 via reciprocal.
// Depends on lsrfe_pkg.
module lsrfe_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lsrfe_pkg::GRB_W-1:0] word_i,
  input  logic [lsrfe_pkg::BRT_W-1:0] bright_i,
  output logic                        done_o,
  output logic [lsrfe_pkg::GRB_W-1:0] word_o
);
  import lsrfe_pkg::*;

  localparam logic [1:0] LAST_CH = 2'd2;

  logic                                 busy_q, busy_d;
  logic                                 done_q, done_d;
  logic                                 ph_q, ph_d;
  logic [1:0]                           ch_q, ch_d;
  logic [GRB_W-1:0]                     src_q, src_d;
  logic [GRB_W-1:0]                     acc_q, acc_d;
  logic [PROD_W-1:0]                    prod_q, prod_d;
  logic [PROD_W+SCALE_RECIP_W-1:0]      recip;

  assign recip = prod_q * SCALE_RECIP;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ph_d   = ph_q;
    ch_d   = ch_q;
    src_d  = src_q;
    acc_d  = acc_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1;
      ph_d   = 1'b0;
      ch_d   = '0;
      src_d  = word_i;
    end else if (busy_q) begin
      if (!ph_q) begin
        prod_d = src_q[GRB_W-1 -: COL_W] * bright_i;
        src_d  = {src_q[GRB_W-COL_W-1:0], {COL_W{1'b0}}};
        ph_d   = 1'b1;
      end else begin
        acc_d = {acc_q[GRB_W-COL_W-1:0], recip[SCALE_SHIFT+COL_W-1:SCALE_SHIFT]};
        ph_d  = 1'b0;
        if (ch_q == LAST_CH) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 1'b0;
      ch_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ph_q   <= ph_d;
      ch_q   <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign word_o = acc_q;

endmodule

>>> rtl/core/lsrfe_div.sv
// Restoring divider for (index * 256) / count, one quotient bit per cycle.
// Depends on lsrfe_pkg; index is always below count.
module lsrfe_div #(
  parameter int unsigned CW = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [CW-1:0]               num_i,
  input  logic [CW-1:0]               den_i,
  output logic                        done_o,
  output logic [lsrfe_pkg::HUE_W-1:0] quot_o
);
  import lsrfe_pkg::*;

  localparam int unsigned SW = $clog2(HUE_W);
  localparam logic [SW-1:0] LAST_STEP = SW'(HUE_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SW-1:0]     step_q, step_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [CW-1:0]     den_q, den_d;
  logic [HUE_W-1:0]  quot_q, quot_d;
  logic [CW:0]       shifted;
  logic [CW:0]       diff;
  logic              ge;

  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[CW-1:0] : shifted[CW-1:0];
      quot_d = {quot_q[HUE_W-2:0], ge};
      step_d = step_q + SW'(1);
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/core/lsrfe_store.sv
// Pixel store: one write port, one registered read port, per-entry valid bits.
// Depends on lsrfe_pkg; an entry never written reads as black.
module lsrfe_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [lsrfe_pkg::GRB_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [lsrfe_pkg::GRB_W-1:0] rdata_o
);
  import lsrfe_pkg::*;

  logic [GRB_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [GRB_W-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

>>> rtl/core/led_strip_rainbow_frame_engine_unit.sv
// LED strip frame engine, top level: sequencer, configuration registers and output stage.
// Depends on lsrfe_pkg, lsrfe_scale, lsrfe_div and lsrfe_store.
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one command: set pixel, fill,
//   hue step, gradient step or show, with a pixel index and a green/red/blue color.
//   The block works on one command at a time and holds in_stall_o high meanwhile.
//   Output channel (out_valid_o / out_stall_i) carries one GRB word per active LED,
//   in index order, with frame_last_o on the final word of the frame.
//   Configuration (APB, pready tied high) holds LED count, brightness and gradient
//   speed; write it only while the block is idle.
// Operation (n = active LED count)
//   Set pixel: scale and write one pixel. Fill: scale, write n pixels. Hue step: fill, then show.
//   Gradient step: each of the n pixels goes through the bit-serial divider (8 steps) and the
//   two-multiplier brightness scaler (6 steps) in turn, then the frame is shown.
//   Show: one store read and one output transfer per pixel.
// Reset clears the sequencer, hue counter and gradient offset and marks every pixel
// black; the block is ready as soon as reset is released. A stall on the output
// holds the current word and pauses the frame walk; nothing is dropped.
module led_strip_rainbow_frame_engine_unit #(
  parameter int unsigned MAX_LEDS = lsrfe_pkg::MAX_LEDS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // command channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lsrfe_pkg::OP_W-1:0]   operation_i,
  input  logic [lsrfe_pkg::IDX_W-1:0]  pixel_index_i,
  input  logic [lsrfe_pkg::COL_W-1:0]  green_in_i,
  input  logic [lsrfe_pkg::COL_W-1:0]  red_in_i,
  input  logic [lsrfe_pkg::COL_W-1:0]  blue_in_i,
  // pixel word channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lsrfe_pkg::GRB_W-1:0]  grb_word_o,
  output logic                         frame_last_o,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsrfe_pkg::CFG_AW-1:0] paddr,
  input  logic [lsrfe_pkg::CFG_DW-1:0] pwdata,
  output logic [lsrfe_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);
  import lsrfe_pkg::*;

  localparam int unsigned CW = $clog2(MAX_LEDS + 1);
  localparam int unsigned AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCALE  = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_GSCALE = 3'd4;
  localparam logic [2:0] ST_RD     = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // configuration registers
  logic [CNT_W-1:0] count_q;
  logic [BRT_W-1:0] bright_q;
  logic [SPD_W-1:0] speed_q;
  logic             cfg_wr;

  // sequencer
  logic [2:0]       state_q, state_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CW-1:0]    pix_q, pix_d;
  logic [HUE_W-1:0] hue_q, hue_d;
  logic [HUE_W-1:0] offset_q, offset_d;
  logic [GRB_W-1:0] word_q, word_d;

  // output stage
  logic             out_valid_q;
  logic [GRB_W-1:0] out_word_q;
  logic             out_last_q;
  logic             out_free;
  logic             out_load;

  // derived settings
  logic [CW-1:0]    n_act;
  logic [CW-1:0]    n_m1;
  logic             n_zero;
  logic             pix_last;
  logic [BRT_W-1:0] bright_eff;
  logic [SPD_W-1:0] speed_eff;
  logic             in_accept;

  // unit hookup
  logic             sc_start;
  logic [GRB_W-1:0] sc_word;
  logic             sc_done;
  logic [GRB_W-1:0] sc_result;
  logic             dv_start;
  logic [CW-1:0]    dv_num;
  logic             dv_done;
  logic [HUE_W-1:0] dv_quot;
  logic             st_we;
  logic [AW-1:0]    st_waddr;
  logic [GRB_W-1:0] st_wdata;
  logic             st_re;
  logic [GRB_W-1:0] st_rdata;

  // Saturate the settings to their legal ranges.
  assign n_act      = (count_q > CNT_W'(MAX_LEDS)) ? CW'(MAX_LEDS) : count_q[CW-1:0];
  assign n_m1       = n_act - CW'(1);
  assign n_zero     = (n_act == '0);
  assign pix_last   = (pix_q == n_m1);
  assign bright_eff = (bright_q > BRIGHT_MAX) ? BRIGHT_MAX : bright_q;
  assign speed_eff  = (speed_q > SPEED_MAX) ? SPEED_MAX : speed_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // A word may enter the output register when it is empty or draining this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= COUNT_RST;
      bright_q <= BRIGHT_RST;
      speed_q  <= SPEED_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        CFG_IDX_COUNT:  count_q  <= pwdata[CNT_W-1:0];
        CFG_IDX_BRIGHT: bright_q <= pwdata[BRT_W-1:0];
        CFG_IDX_SPEED:  speed_q  <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      CFG_IDX_COUNT:  prdata = CFG_DW'(count_q);
      CFG_IDX_BRIGHT: prdata = CFG_DW'(bright_q);
      CFG_IDX_SPEED:  prdata = CFG_DW'(speed_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    idx_d    = idx_q;
    pix_d    = pix_q;
    hue_d    = hue_q;
    offset_d = offset_q;
    word_d   = word_q;
    sc_start = 1'b0;
    sc_word  = {green_in_i, red_in_i, blue_in_i};
    dv_start = 1'b0;
    dv_num   = pix_q;
    st_we    = 1'b0;
    st_waddr = pix_q[AW-1:0];
    st_wdata = word_q;
    st_re    = 1'b0;
    out_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d  = operation_i;
          idx_d = pixel_index_i;
          pix_d = '0;
          case (operation_i)
            OP_SET, OP_FILL: begin
              sc_start = 1'b1;
              state_d  = ST_SCALE;
            end
            OP_HUE: begin
              sc_start = 1'b1;
              sc_word  = wheel_grb(hue_q);
              state_d  = ST_SCALE;
            end
            OP_GRAD: begin
              if (n_zero) begin
                offset_d = offset_q + HUE_W'(speed_eff);
              end else begin
                dv_start = 1'b1;
                dv_num   = '0;
                state_d  = ST_DIV;
              end
            end
            OP_SHOW: begin
              if (!n_zero) begin
                state_d = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // Wait for the scaled color of set pixel, fill or hue step.
      ST_SCALE: begin
        if (sc_done) begin
          word_d = sc_result;
          if (op_q == OP_SET) begin
            if (CNT_W'(idx_q) < CNT_W'(n_act)) begin
              st_we    = 1'b1;
              st_waddr = idx_q[AW-1:0];
              st_wdata = sc_result;
            end
            state_d = ST_IDLE;
          end else if (n_zero) begin
            if (op_q == OP_HUE) begin
              hue_d = hue_q + HUE_W'(1);
            end
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FILL;
          end
        end
      end

      // Write the held color to every active pixel.
      ST_FILL: begin
        st_we = 1'b1;
        if (pix_last) begin
          pix_d   = '0;
          state_d = (op_q == OP_HUE) ? ST_RD : ST_IDLE;
        end else begin
          pix_d = pix_q + CW'(1);
        end
      end

      // Gradient: hue position of the current pixel.
      ST_DIV: begin
        if (dv_done) begin
          sc_start = 1'b1;
          sc_word  = wheel_grb(dv_quot + offset_q);
          state_d  = ST_GSCALE;
        end
      end

      ST_GSCALE: begin
        if (sc_done) begin
          st_we    = 1'b1;
          st_wdata = sc_result;
          if (pix_last) begin
            pix_d   = '0;
            state_d = ST_RD;
          end else begin
            pix_d    = pix_q + CW'(1);
            dv_start = 1'b1;
            dv_num   = pix_q + CW'(1);
            state_d  = ST_DIV;
          end
        end
      end

      ST_RD: begin
        st_re   = 1'b1;
        state_d = ST_OUT;
      end

      // Hand the pixel to the output register; advance hue or offset after the frame.
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pix_last) begin
            if (op_q == OP_HUE) begin
              hue_d = hue_q + HUE_W'(1);
            end else if (op_q == OP_GRAD) begin
              offset_d = offset_q + HUE_W'(speed_eff);
            end
            state_d = ST_IDLE;
          end else begin
            pix_d   = pix_q + CW'(1);
            state_d = ST_RD;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_SHOW;
      pix_q    <= '0;
      hue_q    <= '0;
      offset_q <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      pix_q    <= pix_d;
      hue_q    <= hue_d;
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    word_q <= word_d;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= st_rdata;
      out_last_q <= pix_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign grb_word_o   = out_word_q;
  assign frame_last_o = out_last_q;

  // ---------------------------------------------------------------------------
  // Units
  // ---------------------------------------------------------------------------
  lsrfe_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sc_start),
    .word_i   (sc_word),
    .bright_i (bright_eff),
    .done_o   (sc_done),
    .word_o   (sc_result)
  );

  lsrfe_div #(
    .CW (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (n_act),
    .done_o  (dv_done),
    .quot_o  (dv_quot)
  );

  lsrfe_store #(
    .DEPTH (MAX_LEDS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (pix_q[AW-1:0]),
    .rdata_o (st_rdata)
  );

endmodule

>>> rtl/core/lsrfe_checker.sv
// Port-level checker for the LED strip frame engine, bound to the top level.
// Depends on led_strip_rainbow_frame_engine_unit_macros.svh and lsrfe_pkg.
`include "led_strip_rainbow_frame_engine_unit_macros.svh"

module lsrfe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lsrfe_pkg::GRB_W-1:0] grb_word_o,
  input logic                        frame_last_o
);
  import lsrfe_pkg::*;

  // A stalled word holds.
  `LSRFE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(grb_word_o) && $stable(frame_last_o), "stalled pixel word changed")

  // A word only appears while a command is in progress.
  `LSRFE_ASSERT(a_out_busy, $rose(out_valid_o) |-> $past(in_stall_o), "pixel word without command in progress")

  // Handshake outputs are always driven to a known level.
  `LSRFE_ASSERT(a_hs_known, !$isunknown({in_stall_o, out_valid_o}), "handshake output unknown")

endmodule

bind led_strip_rainbow_frame_engine_unit lsrfe_checker u_lsrfe_checker (.*);
